[rtl/core/hsar_pkg.sv]
package hsar_pkg;

	// Field and datapath widths.
	localparam int ChanW    = 8;
	localparam int PixW     = 3 * ChanW;
	localparam int SplatW   = 10;
	localparam int FracCfgW = 9;
	localparam int GainW    = 10;
	localparam int DimW     = 9;
	localparam int SideInW  = 6;
	localparam int CfgIdxW  = 3;
	localparam int HashW    = 16;
	localparam int KhiW     = HashW + GainW;
	localparam int KcW      = HashW + KhiW;
	localparam int MagW     = ChanW + KcW;
	localparam int FracBits = 40;

	// Defaults for the top-level parameters.
	localparam int StampKindsDef   = 16;
	localparam int MaxStampSideDef = 32;
	localparam int MaxImageSideDef = 256;

	// Largest splat count a run may draw.
	localparam int MaxSplats = 1023;

	// Hash constants.
	localparam logic [31:0] HASH_OFS_A = 32'd12345;
	localparam logic [31:0] HASH_OFS_B = 32'd67890;
	localparam logic [31:0] HASH_OFS_C = 32'd13579;
	localparam logic [31:0] HASH_MUL_A = 32'd374761393;
	localparam logic [31:0] HASH_MUL_B = 32'd668265263;
	localparam logic [31:0] HASH_MUL_C = 32'd1103515245;
	localparam logic [31:0] HASH_MUL_D = 32'd1274126177;

	// Hash keys that select each random quantity.
	localparam logic [31:0] KEY_COUNT = 32'd777;
	localparam logic [31:0] KEY_STAMP = 32'd100;
	localparam logic [31:0] KEY_X     = 32'd200;
	localparam logic [31:0] KEY_Y     = 32'd300;
	localparam logic [31:0] KEY_RED   = 32'd400;
	localparam logic [31:0] KEY_GREEN = 32'd500;
	localparam logic [31:0] KEY_BLUE  = 32'd600;
	localparam logic [31:0] KEY_GREY  = 32'd700;
	localparam logic [31:0] KEY_INT   = 32'd800;
	localparam logic [31:0] KEY_POL   = 32'd900;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_SEED   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_COUNT  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LOFRAC = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_COLOR  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_GAIN   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 3'd6;

	typedef enum logic [2:0] {
		KIND_PIX_WR  = 3'd0,
		KIND_TEX_WR  = 3'd1,
		KIND_SIDE_WR = 3'd2,
		KIND_RUN     = 3'd3,
		KIND_PIX_RD  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RUN0, S_HCNT, S_SPLAT, S_HSPL, S_SIDE,
		S_GEO, S_KCB, S_TRD, S_TMUL, S_TWR, S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         pos_x;
		logic [7:0]         pos_y;
		logic [ChanW-1:0]   in_red;
		logic [ChanW-1:0]   in_green;
		logic [ChanW-1:0]   in_blue;
		logic [3:0]         stamp_number;
		logic [7:0]         texel_alpha;
		logic [SideInW-1:0] stamp_side;
	} item_t;

	typedef struct packed {
		logic [ChanW-1:0]  out_red;
		logic [ChanW-1:0]  out_green;
		logic [ChanW-1:0]  out_blue;
		logic              run_done;
		logic [SplatW-1:0] splats_drawn;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} hash_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [HashW-1:0] h;
	} hash_rsp_t;

endpackage

[rtl/core/hsar_ram.sv]
module hsar_ram #(
	parameter int Depth = 16,
	parameter int Width = 8,
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [Aw-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [Aw-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/hsar_hash.sv]
module hsar_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  hsar_pkg::hash_req_t req,
	output hsar_pkg::hash_rsp_t rsp
);
	import hsar_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [1:0]       phase_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      c_q;
	logic [31:0]      acc_q;
	logic [HashW-1:0] h_q;
	logic [31:0]      mixed;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [31:0]      prod;

	// One shared multiplier, one product term per phase.
	always_comb begin
		mixed = acc_q ^ (acc_q >> 13);
		unique case (phase_q)
			2'd0: begin
				mul_a = a_q;
				mul_b = HASH_MUL_A;
			end
			2'd1: begin
				mul_a = b_q;
				mul_b = HASH_MUL_B;
			end
			2'd2: begin
				mul_a = c_q;
				mul_b = HASH_MUL_C;
			end
			2'd3: begin
				mul_a = mixed;
				mul_b = HASH_MUL_D;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Phase control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= '0;
		end else if (req.start && !busy_q) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			phase_q <= '0;
		end else if (busy_q) begin
			phase_q <= phase_q + 2'd1;
			if (phase_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and accumulator.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q <= req.a + HASH_OFS_A;
			b_q <= req.b + HASH_OFS_B;
			c_q <= req.c + HASH_OFS_C;
		end else if (busy_q) begin
			unique case (phase_q)
				2'd0: acc_q <= prod;
				2'd1: acc_q <= acc_q + prod;
				2'd2: acc_q <= acc_q + prod;
				2'd3: h_q <= prod[30:15];
			endcase
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, h: h_q};

endmodule

[rtl/core/hsar_blend.sv]
module hsar_blend (
	input  logic [hsar_pkg::PixW-1:0]      pix,
	input  logic [2:0][hsar_pkg::MagW-1:0] mag,
	input  logic                           plus,
	output logic [hsar_pkg::PixW-1:0]      blended
);
	import hsar_pkg::*;

	localparam int WholeW = MagW - FracBits;

	// Add or subtract the magnitude on each channel; floor and clamp to 0..255.
	always_comb begin
		logic [ChanW-1:0]  chan;
		logic [WholeW-1:0] whole;
		logic [WholeW-1:0] chan_x;
		logic              frac_nz;
		logic [WholeW:0]   sum;
		logic [WholeW-1:0] diff;
		logic [ChanW-1:0]  res;
		blended = '0;
		for (int c = 0; c < 3; c++) begin
			chan    = pix[PixW-1-ChanW*c -: ChanW];
			whole   = mag[c][MagW-1:FracBits];
			frac_nz = |mag[c][FracBits-1:0];
			chan_x  = WholeW'(chan);
			sum     = (WholeW+1)'(chan_x) + (WholeW+1)'(whole);
			diff    = chan_x - whole - WholeW'(frac_nz);
			if (plus) begin
				res = (sum > (WholeW+1)'(8'hff)) ? 8'hff : sum[ChanW-1:0];
			end else if ((chan_x < whole) || ((chan_x == whole) && frac_nz)) begin
				res = '0;
			end else begin
				res = diff[ChanW-1:0];
			end
			blended[PixW-1-ChanW*c -: ChanW] = res;
		end
	end

endmodule

[rtl/core/hashed_splat_accent_renderer.sv]
// Channel  | Handshake                  | Beat
// item     | item_valid / item_stall    | one hsar_pkg::item_t per accepted beat
// result   | result_valid / result_stall| one hsar_pkg::result_t for each run or pixel read
// cfg      | cfg_valid / cfg_ready      | cfg_index selects a register, cfg_data is written
//
// Pixel, texel and stamp side writes are made when the item is accepted; a pixel read
// goes through S_RD into the output register. All hashes share one four-phase hash unit.
// A run draws each splat with eight hashes in per-channel color mode and six in grey
// mode, with setup in S_SPLAT, S_SIDE, S_GEO and S_KCB. A texel inside the frame takes
// the frame read-modify-write states S_TRD, S_TMUL and S_TWR; a clipped one only S_TRD.
// The result sits in an output register; result_stall only holds that register and
// the final step of a read or a run. Reset clears control and configuration; the
// frame, texel and side memories hold no defined value until written.
module hashed_splat_accent_renderer #(
	parameter int STAMP_KINDS    = hsar_pkg::StampKindsDef,
	parameter int MAX_STAMP_SIDE = hsar_pkg::MaxStampSideDef,
	parameter int MAX_IMAGE_SIDE = hsar_pkg::MaxImageSideDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  hsar_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output hsar_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hsar_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]                   cfg_data
);
	import hsar_pkg::*;

	localparam int FrameDepth = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
	localparam int FrameAw    = $clog2(FrameDepth);
	localparam int TexDepth   = STAMP_KINDS * MAX_STAMP_SIDE * MAX_STAMP_SIDE;
	localparam int TexAw      = (TexDepth > 1) ? $clog2(TexDepth) : 1;
	localparam int StW        = (STAMP_KINDS > 1) ? $clog2(STAMP_KINDS) : 1;
	localparam int SideW      = $clog2(MAX_STAMP_SIDE + 1);
	localparam int TxW        = (MAX_STAMP_SIDE > 1) ? $clog2(MAX_STAMP_SIDE) : 1;
	localparam int PosW       = $clog2(MAX_IMAGE_SIDE + MAX_STAMP_SIDE) + 2;

	// Configuration registers.
	logic [31:0]         seed_q;
	logic [SplatW-1:0]   splat_count_q;
	logic [FracCfgW-1:0] low_frac_q;
	logic                color_mode_q;
	logic [GainW-1:0]    gain_q;
	logic [DimW-1:0]     width_q;
	logic [DimW-1:0]     height_q;

	// Sequencer state.
	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [SplatW-1:0] splat_counter_q;
	logic [SplatW-1:0] lo_q;
	logic [SplatW-1:0] i_q;
	logic [2:0]        step_q;
	logic [2:0]        step_nx;
	logic [TxW-1:0]    px_q;
	logic [TxW-1:0]    py_q;

	// Per-splat values.
	logic [StW-1:0]              st_q;
	logic [DimW-1:0]             cx_q;
	logic [DimW-1:0]             cy_q;
	logic [2:0][HashW-1:0]       hc_q;
	logic [KhiW-1:0]             khi_q;
	logic [2:0][KcW-1:0]         kc_q;
	logic                        plus_q;
	logic [SideW-1:0]            side_q;
	logic signed [PosW-1:0]      x0_q;
	logic signed [PosW-1:0]      y0_q;
	logic [2:0][MagW-1:0]        mag_q;
	logic                        rd_ok_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;
	logic    out_free;
	logic    load_out;

	// Effective configuration.
	logic [SplatW-1:0]   cnt_eff;
	logic [FracCfgW-1:0] frac_eff;
	logic [DimW-1:0]     w_eff;
	logic [DimW-1:0]     h_eff;

	// Item decode.
	logic               accept;
	logic               pix_in_range;
	logic               tex_in_range;
	logic               side_in_range;
	logic [FrameAw-1:0] item_frame_addr;
	logic [TexAw-1:0]   item_tex_addr;

	// Texel walk.
	logic signed [PosW-1:0] px_ext;
	logic signed [PosW-1:0] py_ext;
	logic signed [PosW-1:0] wx;
	logic signed [PosW-1:0] wy;
	logic [PosW-1:0]        wx_u;
	logic [PosW-1:0]        wy_u;
	logic                   texel_in;
	logic                   last_col;
	logic                   last_row;
	logic                   texel_last;
	logic [SideW-1:0]       side_eff;

	// Memory ports.
	logic               frame_we;
	logic [FrameAw-1:0] frame_waddr;
	logic [PixW-1:0]    frame_wdata;
	logic               frame_re;
	logic [FrameAw-1:0] frame_raddr;
	logic [PixW-1:0]    frame_rdata;
	logic               tex_we;
	logic               tex_re;
	logic [TexAw-1:0]   tex_raddr;
	logic [7:0]         tex_rdata;
	logic               side_we;
	logic               side_re;
	logic [SideInW-1:0] side_rdata;
	logic [PixW-1:0]    blended;

	hash_req_t hash_req;
	hash_rsp_t hash_rsp;

	function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0) begin
			r = DimW'(1);
		end else if (32'(v) > MAX_IMAGE_SIDE) begin
			r = DimW'(MAX_IMAGE_SIDE);
		end
		return r;
	endfunction

	function automatic logic [31:0] step_key(logic [2:0] s, logic per_chan);
		logic [31:0] k;
		unique case (s)
			3'd0: k = KEY_STAMP;
			3'd1: k = KEY_X;
			3'd2: k = KEY_Y;
			3'd3: k = per_chan ? KEY_RED : KEY_GREY;
			3'd4: k = KEY_GREEN;
			3'd5: k = KEY_BLUE;
			3'd6: k = KEY_INT;
			3'd7: k = KEY_POL;
		endcase
		return k;
	endfunction

	// Clamp the configuration to what the datapath supports.
	assign cnt_eff  = (32'(splat_count_q) > MaxSplats) ? SplatW'(MaxSplats) : splat_count_q;
	assign frac_eff = (low_frac_q > FracCfgW'(256)) ? FracCfgW'(256) : low_frac_q;
	assign w_eff    = clamp_dim(width_q);
	assign h_eff    = clamp_dim(height_q);

	// Input handshake and address decode.
	assign item_stall      = (state_q != S_IDLE);
	assign accept          = item_valid && !item_stall;
	assign pix_in_range    = (32'(item.pos_x) < MAX_IMAGE_SIDE) &&
	                         (32'(item.pos_y) < MAX_IMAGE_SIDE);
	assign side_in_range   = (32'(item.stamp_number) < STAMP_KINDS);
	assign tex_in_range    = side_in_range && (32'(item.pos_x) < MAX_STAMP_SIDE) &&
	                         (32'(item.pos_y) < MAX_STAMP_SIDE);
	assign item_frame_addr = FrameAw'(32'(item.pos_y) * MAX_IMAGE_SIDE + 32'(item.pos_x));
	assign item_tex_addr   = TexAw'((32'(item.stamp_number) * MAX_STAMP_SIDE +
	                         32'(item.pos_y)) * MAX_STAMP_SIDE + 32'(item.pos_x));

	// Frame coordinates of the current texel and the end of the walk.
	assign px_ext     = PosW'(px_q);
	assign py_ext     = PosW'(py_q);
	assign wx         = x0_q + px_ext;
	assign wy         = y0_q + py_ext;
	assign wx_u       = unsigned'(wx);
	assign wy_u       = unsigned'(wy);
	assign texel_in   = (wx >= 0) && (wx < $signed(PosW'(w_eff))) &&
	                    (wy >= 0) && (wy < $signed(PosW'(h_eff)));
	assign last_col   = (32'(px_q) == 32'(side_q) - 1);
	assign last_row   = (32'(py_q) == 32'(side_q) - 1);
	assign texel_last = last_col && last_row;
	assign side_eff   = (32'(side_rdata) > MAX_STAMP_SIDE) ? SideW'(MAX_STAMP_SIDE)
	                                                      : SideW'(side_rdata);
	assign step_nx    = (step_q == 3'd3 && !color_mode_q) ? 3'd6 : step_q + 3'd1;

	assign out_free = !out_valid_q || !result_stall;
	assign load_out = ((state_q == S_RD) || (state_q == S_DONE)) && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item.kind == KIND_RUN) begin
					state_d = S_RUN0;
				end else if (accept && item.kind == KIND_PIX_RD) begin
					state_d = S_RD;
				end
			end
			S_RD:    if (out_free) state_d = S_IDLE;
			S_RUN0:  state_d = (gain_q == '0) ? S_DONE : S_HCNT;
			S_HCNT:  if (hash_rsp.done) state_d = S_SPLAT;
			S_SPLAT: state_d = (i_q == splat_counter_q) ? S_DONE : S_HSPL;
			S_HSPL:  if (hash_rsp.done && step_q == 3'd7) state_d = S_SIDE;
			S_SIDE:  state_d = S_GEO;
			S_GEO:   state_d = S_KCB;
			S_KCB:   state_d = (side_q == '0) ? S_SPLAT : S_TRD;
			S_TRD: begin
				if (texel_in) begin
					state_d = S_TMUL;
				end else if (texel_last) begin
					state_d = S_SPLAT;
				end
			end
			S_TMUL:  state_d = S_TWR;
			S_TWR:   state_d = texel_last ? S_SPLAT : S_TRD;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory enables and hash requests.
	always_comb begin
		frame_we      = 1'b0;
		frame_waddr   = item_frame_addr;
		frame_wdata   = {item.in_red, item.in_green, item.in_blue};
		frame_re      = 1'b0;
		frame_raddr   = item_frame_addr;
		tex_we        = 1'b0;
		tex_re        = 1'b0;
		tex_raddr     = TexAw'((32'(st_q) * MAX_STAMP_SIDE + 32'(py_q)) * MAX_STAMP_SIDE
		                + 32'(px_q));
		side_we       = 1'b0;
		side_re       = 1'b0;
		hash_req      = '{start: 1'b0, a: 32'(i_q), b: step_key(step_nx, color_mode_q),
		                  c: seed_q};
		unique case (state_q)
			S_IDLE: begin
				frame_we = accept && item.kind == KIND_PIX_WR && pix_in_range;
				tex_we   = accept && item.kind == KIND_TEX_WR && tex_in_range;
				side_we  = accept && item.kind == KIND_SIDE_WR && side_in_range;
				frame_re = accept && item.kind == KIND_PIX_RD && pix_in_range;
			end
			S_RUN0: begin
				hash_req = '{start: (gain_q != '0), a: seed_q, b: '0, c: KEY_COUNT};
			end
			S_SPLAT: begin
				hash_req.start = (i_q != splat_counter_q);
				hash_req.b     = step_key(3'd0, color_mode_q);
			end
			S_HSPL: begin
				hash_req.start = hash_rsp.done && (step_q != 3'd7);
			end
			S_SIDE: begin
				side_re = 1'b1;
			end
			S_TRD: begin
				frame_raddr = FrameAw'(32'(wy_u) * MAX_IMAGE_SIDE + 32'(wx_u));
				frame_re    = texel_in;
				tex_re      = texel_in;
			end
			S_TWR: begin
				frame_waddr = FrameAw'(32'(wy_u) * MAX_IMAGE_SIDE + 32'(wx_u));
				frame_wdata = blended;
				frame_we    = (tex_rdata != '0);
			end
			default: begin
			end
		endcase
	end

	// Control registers, configuration and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			out_valid_q     <= 1'b0;
			splat_counter_q <= '0;
			i_q             <= '0;
			step_q          <= '0;
			px_q            <= '0;
			py_q            <= '0;
			seed_q          <= '0;
			splat_count_q   <= '0;
			low_frac_q      <= '0;
			color_mode_q    <= 1'b0;
			gain_q          <= GainW'(256);
			width_q         <= DimW'(256);
			height_q        <= DimW'(256);
		end else begin
			state_q <= state_d;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SEED:   seed_q        <= cfg_data;
					CFG_COUNT:  splat_count_q <= cfg_data[SplatW-1:0];
					CFG_LOFRAC: low_frac_q    <= cfg_data[FracCfgW-1:0];
					CFG_COLOR:  color_mode_q  <= cfg_data[0];
					CFG_GAIN:   gain_q        <= cfg_data[GainW-1:0];
					CFG_WIDTH:  width_q       <= cfg_data[DimW-1:0];
					CFG_HEIGHT: height_q      <= cfg_data[DimW-1:0];
					default: begin
					end
				endcase
			end

			// Splat count, hash steps and texel walk.
			unique case (state_q)
				S_RUN0: begin
					if (gain_q == '0) begin
						splat_counter_q <= '0;
					end
				end
				S_HCNT: begin
					if (hash_rsp.done) begin
						splat_counter_q <= lo_q + SplatW'((26'(hash_rsp.h) *
						                   26'(cnt_eff - lo_q)) >> 16);
						i_q <= '0;
					end
				end
				S_SPLAT: begin
					step_q <= '0;
				end
				S_HSPL: begin
					if (hash_rsp.done) begin
						step_q <= step_nx;
					end
				end
				S_KCB: begin
					px_q <= '0;
					py_q <= '0;
					if (side_q == '0) begin
						i_q <= i_q + SplatW'(1);
					end
				end
				S_TRD, S_TWR: begin
					if ((state_q == S_TWR) || !texel_in) begin
						if (last_col) begin
							px_q <= '0;
							if (last_row) begin
								py_q <= '0;
								i_q  <= i_q + SplatW'(1);
							end else begin
								py_q <= py_q + TxW'(1);
							end
						end else begin
							px_q <= px_q + TxW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_q <= pix_in_range;
		end
		if (load_out) begin
			if (state_q == S_RD) begin
				out_q.out_red      <= rd_ok_q ? frame_rdata[PixW-1 -: ChanW] : '0;
				out_q.out_green    <= rd_ok_q ? frame_rdata[2*ChanW-1 -: ChanW] : '0;
				out_q.out_blue     <= rd_ok_q ? frame_rdata[ChanW-1:0] : '0;
				out_q.run_done     <= 1'b0;
				out_q.splats_drawn <= '0;
			end else begin
				out_q.out_red      <= '0;
				out_q.out_green    <= '0;
				out_q.out_blue     <= '0;
				out_q.run_done     <= 1'b1;
				out_q.splats_drawn <= splat_counter_q;
			end
		end

		unique case (state_q)
			S_RUN0: begin
				lo_q <= SplatW'((19'(cnt_eff) * 19'(frac_eff)) >> 8);
			end
			S_HSPL: begin
				if (hash_rsp.done) begin
					unique case (step_q)
						3'd0: st_q <= StW'((32'(hash_rsp.h) * STAMP_KINDS) >> 16);
						3'd1: cx_q <= DimW'((25'(hash_rsp.h) * 25'(w_eff)) >> 16);
						3'd2: cy_q <= DimW'((25'(hash_rsp.h) * 25'(h_eff)) >> 16);
						3'd3: begin
							hc_q[0] <= hash_rsp.h;
							if (!color_mode_q) begin
								hc_q[1] <= hash_rsp.h;
								hc_q[2] <= hash_rsp.h;
							end
						end
						3'd4: hc_q[1] <= hash_rsp.h;
						3'd5: hc_q[2] <= hash_rsp.h;
						3'd6: khi_q <= KhiW'(hash_rsp.h) * KhiW'(gain_q);
						3'd7: plus_q <= (hash_rsp.h > HashW'(32768));
					endcase
				end
			end
			S_SIDE: begin
				kc_q[0] <= KcW'(hc_q[0]) * KcW'(khi_q);
			end
			S_GEO: begin
				side_q  <= side_eff;
				x0_q    <= $signed(PosW'(cx_q)) - $signed(PosW'(side_eff >> 1));
				y0_q    <= $signed(PosW'(cy_q)) - $signed(PosW'(side_eff >> 1));
				kc_q[1] <= KcW'(hc_q[1]) * KcW'(khi_q);
			end
			S_KCB: begin
				kc_q[2] <= KcW'(hc_q[2]) * KcW'(khi_q);
			end
			S_TMUL: begin
				for (int c = 0; c < 3; c++) begin
					mag_q[c] <= MagW'(tex_rdata) * MagW'(kc_q[c]);
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign cfg_ready    = 1'b1;

	hsar_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hash_req),
		.rsp    (hash_rsp)
	);

	hsar_blend u_blend (
		.pix     (frame_rdata),
		.mag     (mag_q),
		.plus    (plus_q),
		.blended (blended)
	);

	hsar_ram #(.Depth(FrameDepth), .Width(PixW)) u_frame (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (frame_wdata),
		.re    (frame_re),
		.raddr (frame_raddr),
		.rdata (frame_rdata)
	);

	hsar_ram #(.Depth(TexDepth), .Width(8)) u_texels (
		.clk   (clk),
		.we    (tex_we),
		.waddr (item_tex_addr),
		.wdata (item.texel_alpha),
		.re    (tex_re),
		.raddr (tex_raddr),
		.rdata (tex_rdata)
	);

	hsar_ram #(.Depth(STAMP_KINDS), .Width(SideInW)) u_sides (
		.clk   (clk),
		.we    (side_we),
		.waddr (StW'(item.stamp_number)),
		.wdata (item.stamp_side),
		.re    (side_re),
		.raddr (st_q),
		.rdata (side_rdata)
	);

	// The hash unit is only started when it is free.
	a_hash_free: assert property (@(posedge clk) disable iff (!arst_n)
		hash_req.start |-> !hash_rsp.busy)
		else $error("hash started while busy");

	// Frame writes come only from a pixel write beat or the blend step.
	a_frame_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		frame_we |-> (state_q == S_IDLE || state_q == S_TWR))
		else $error("frame write outside write or blend step");

	// A texel read is always followed by the multiply step.
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRD && frame_re) |=> (state_q == S_TMUL))
		else $error("texel read not followed by multiply");

	// A finished run never reports more splats than the clamped count.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && state_q == S_DONE) |-> (splat_counter_q <= cnt_eff))
		else $error("splat count above limit");

endmodule
